/* src/elp_pkg.sv */
package elp_pkg;

    localparam logic [2:0] PH_START  = 3'd0;
    localparam logic [2:0] PH_SRC    = 3'd1;
    localparam logic [2:0] PH_WS_DST = 3'd2;
    localparam logic [2:0] PH_DST    = 3'd3;
    localparam logic [2:0] PH_WS_WT  = 3'd4;
    localparam logic [2:0] PH_WT     = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOSRC = 2'd1;
    localparam logic [1:0] ST_NODST = 2'd2;
    localparam logic [1:0] ST_NOWT  = 2'd3;

    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_VT    = 8'd11;
    localparam logic [7:0] CH_FF    = 8'd12;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_HASH  = 8'd35;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;

    localparam int unsigned VERTEX_W = 64;
    localparam int unsigned WEIGHT_W = 32;
    localparam int unsigned APB_AW   = 3;
    localparam int unsigned APB_DW   = 32;

    localparam logic REG_WEIGHTED_MODE = 1'b0;

    typedef logic [VERTEX_W-1:0] t_vertex;
    typedef logic [WEIGHT_W-1:0] t_weight;

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_VT) ||
               (b == CH_FF) || (b == CH_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    // Multiply by ten and add a digit, saturating at the maximum value.
    function automatic t_vertex acc_vertex(input t_vertex a, input logic [3:0] d);
        logic [VERTEX_W+3:0] sum;
        sum = {1'b0, a, 3'b000} + {3'b000, a, 1'b0} + {{VERTEX_W{1'b0}}, d};
        return (sum[VERTEX_W+3:VERTEX_W] != 4'd0) ? {VERTEX_W{1'b1}} : sum[VERTEX_W-1:0];
    endfunction

    function automatic t_weight acc_weight(input t_weight a, input logic [3:0] d);
        logic [WEIGHT_W+3:0] sum;
        sum = {1'b0, a, 3'b000} + {3'b000, a, 1'b0} + {{WEIGHT_W{1'b0}}, d};
        return (sum[WEIGHT_W+3:WEIGHT_W] != 4'd0) ? {WEIGHT_W{1'b1}} : sum[WEIGHT_W-1:0];
    endfunction

endpackage

/* src/elp_in_if.sv */
interface elp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

/* src/elp_out_if.sv */
interface elp_out_if;
    logic               valid;
    logic               ready;
    elp_pkg::t_vertex   source_vertex;
    elp_pkg::t_vertex   dest_vertex;
    elp_pkg::t_weight   edge_weight;
    logic [1:0]         line_status;

    modport source (output valid, output source_vertex, output dest_vertex,
                    output edge_weight, output line_status, input ready);
    modport sink (input valid, input source_vertex, input dest_vertex,
                  input edge_weight, input line_status, output ready);
endinterface

/* src/edge_list_text_parser.sv */
// Parses a decimal edge list one text byte per beat and returns at most one edge beat per line.
// A byte is taken every cycle while results are taken; it is held in the input register and
// parsed from there, and the edge or error it causes is registered into the output register.
// The rate is set by the parse step, whose longest path is the 64-bit
// multiply-by-ten-and-add with saturation. The weighted_mode register at address 0 may only be
// written while no byte is in flight.
module edge_list_text_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [elp_pkg::APB_AW-1:0]    paddr,
    input  logic [elp_pkg::APB_DW-1:0]    pwdata,
    output logic [elp_pkg::APB_DW-1:0]    prdata,
    output logic                          pready,
    elp_in_if.sink                        i_in,
    elp_out_if.source                     o_out
);

    logic              r_weighted_mode;

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_in_eot;

    logic [2:0]        r_phase,  n_phase;
    logic              r_done,   n_done;
    elp_pkg::t_vertex  r_src,    n_src;
    elp_pkg::t_vertex  r_dst,    n_dst;
    elp_pkg::t_weight  r_wt,     n_wt;

    logic              r_out_valid;
    elp_pkg::t_vertex  r_out_src,    n_out_src;
    elp_pkg::t_vertex  r_out_dst,    n_out_dst;
    elp_pkg::t_weight  r_out_wt,     n_out_wt;
    logic [1:0]        r_out_status, n_out_status;
    logic              n_emit;

    logic              proc_adv;
    logic              in_take;
    logic [7:0]        cur_byte;
    logic              eol;
    logic              dig;
    logic              sp;
    logic [3:0]        dval;
    logic              reg_sel;

    assign reg_sel = (paddr[2] == elp_pkg::REG_WEIGHTED_MODE);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? {{(elp_pkg::APB_DW-1){1'b0}}, r_weighted_mode}
                             : {elp_pkg::APB_DW{1'b0}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weighted_mode <= 1'b0;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_weighted_mode <= pwdata[0];
        end
    end

    assign proc_adv   = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || proc_adv;
    assign in_take    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_in.text_byte;
            r_in_eot  <= i_in.end_of_text;
        end
    end

    assign cur_byte = r_in_eot ? elp_pkg::CH_LF : r_in_byte;
    assign eol      = (cur_byte == elp_pkg::CH_LF);
    assign dig      = elp_pkg::is_digit(cur_byte);
    assign sp       = elp_pkg::is_blank(cur_byte);
    assign dval     = dig ? 4'(cur_byte - elp_pkg::CH_ZERO) : 4'd0;

    always_comb begin
        n_phase      = r_phase;
        n_done       = r_done;
        n_src        = r_src;
        n_dst        = r_dst;
        n_wt         = r_wt;
        n_emit       = 1'b0;
        n_out_src    = '0;
        n_out_dst    = '0;
        n_out_wt     = '0;
        n_out_status = elp_pkg::ST_OK;
        if (r_done) begin
            if (eol) begin
                n_done = 1'b0;
            end
        end else begin
            unique case (r_phase)
                elp_pkg::PH_START: begin
                    if (eol || sp) begin
                        n_phase = elp_pkg::PH_START;
                    end else if (cur_byte == elp_pkg::CH_NUL ||
                                 cur_byte == elp_pkg::CH_HASH) begin
                        n_done = 1'b1;
                    end else if (dig) begin
                        n_src   = {{(elp_pkg::VERTEX_W-4){1'b0}}, dval};
                        n_phase = elp_pkg::PH_SRC;
                    end else begin
                        n_done       = 1'b1;
                        n_emit       = 1'b1;
                        n_out_status = elp_pkg::ST_NOSRC;
                    end
                end
                elp_pkg::PH_SRC: begin
                    if (dig) begin
                        n_src = elp_pkg::acc_vertex(r_src, dval);
                    end else if (sp) begin
                        n_phase = elp_pkg::PH_WS_DST;
                    end else begin
                        n_phase      = elp_pkg::PH_START;
                        n_done       = !eol;
                        n_emit       = 1'b1;
                        n_out_status = elp_pkg::ST_NODST;
                    end
                end
                elp_pkg::PH_WS_DST: begin
                    if (sp) begin
                        n_phase = elp_pkg::PH_WS_DST;
                    end else if (dig) begin
                        n_dst   = {{(elp_pkg::VERTEX_W-4){1'b0}}, dval};
                        n_phase = elp_pkg::PH_DST;
                    end else begin
                        n_phase      = elp_pkg::PH_START;
                        n_done       = !eol;
                        n_emit       = 1'b1;
                        n_out_status = elp_pkg::ST_NODST;
                    end
                end
                elp_pkg::PH_DST: begin
                    if (dig) begin
                        n_dst = elp_pkg::acc_vertex(r_dst, dval);
                    end else if (!r_weighted_mode) begin
                        n_phase   = elp_pkg::PH_START;
                        n_done    = !eol;
                        n_emit    = 1'b1;
                        n_out_src = r_src;
                        n_out_dst = r_dst;
                        n_out_wt  = {{(elp_pkg::WEIGHT_W-1){1'b0}}, 1'b1};
                    end else if (sp) begin
                        n_phase = elp_pkg::PH_WS_WT;
                    end else begin
                        n_phase      = elp_pkg::PH_START;
                        n_done       = !eol;
                        n_emit       = 1'b1;
                        n_out_status = elp_pkg::ST_NOWT;
                    end
                end
                elp_pkg::PH_WS_WT: begin
                    if (sp) begin
                        n_phase = elp_pkg::PH_WS_WT;
                    end else if (dig) begin
                        n_wt    = {{(elp_pkg::WEIGHT_W-4){1'b0}}, dval};
                        n_phase = elp_pkg::PH_WT;
                    end else begin
                        n_phase      = elp_pkg::PH_START;
                        n_done       = !eol;
                        n_emit       = 1'b1;
                        n_out_status = elp_pkg::ST_NOWT;
                    end
                end
                elp_pkg::PH_WT: begin
                    if (dig) begin
                        n_wt = elp_pkg::acc_weight(r_wt, dval);
                    end else begin
                        n_phase   = elp_pkg::PH_START;
                        n_done    = !eol;
                        n_emit    = 1'b1;
                        n_out_src = r_src;
                        n_out_dst = r_dst;
                        n_out_wt  = r_wt;
                    end
                end
                default: begin
                    n_phase = elp_pkg::PH_START;
                    n_done  = !eol;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= elp_pkg::PH_START;
            r_done  <= 1'b0;
        end else if (proc_adv) begin
            r_phase <= n_phase;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_adv) begin
            r_src <= n_src;
            r_dst <= n_dst;
            r_wt  <= n_wt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_adv && n_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_adv && n_emit) begin
            r_out_src    <= n_out_src;
            r_out_dst    <= n_out_dst;
            r_out_wt     <= n_out_wt;
            r_out_status <= n_out_status;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.source_vertex = r_out_src;
    assign o_out.dest_vertex   = r_out_dst;
    assign o_out.edge_weight   = r_out_wt;
    assign o_out.line_status   = r_out_status;

`ifndef NO_ASSERTIONS
    a_done_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_phase == elp_pkg::PH_START))
        else $error("line drop flag set outside line start");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= elp_pkg::PH_WT)
        else $error("parse phase out of range");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != elp_pkg::ST_OK) |->
        (r_out_src == '0 && r_out_dst == '0 && r_out_wt == '0))
        else $error("error result carries nonzero fields");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !proc_adv) |=> (r_in_valid && $stable(r_in_byte) && $stable(r_in_eot)))
        else $error("stalled input byte lost or changed");
`endif

endmodule
